[rtl/fded_pkg.sv]
// Package for the four-direction edge detector: field widths, register indexes,
// reset values and the small arithmetic helpers of the gradient datapath.
// Depends on nothing; every other file of the block but fded_ram imports it.
package fded_pkg;

    // Default sizes of the line buffers and of the frame.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int WIN_DIM        = 3;
    localparam int ADAPT_FACTOR   = 12;

    // Payload widths.
    localparam int PIXEL_W = 8;
    localparam int CROW_W  = 10;
    localparam int CCOL_W  = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int IMG_WIDTH_W  = 9;
    localparam int IMG_HEIGHT_W = 11;
    localparam int THRESH_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd3;

    localparam logic [IMG_WIDTH_W-1:0]  IMAGE_WIDTH_RST    = 9'd188;
    localparam logic [IMG_HEIGHT_W-1:0] IMAGE_HEIGHT_RST   = 11'd120;
    localparam logic                    ADAPTIVE_MODE_RST  = 1'b0;
    localparam logic [THRESH_W-1:0]     EDGE_THRESHOLD_RST = 8'd80;

    // Sum of three pixels and a gradient magnitude both fit in ten bits.
    localparam int SUM3_W = 10;
    localparam int SUM9_W = 12;
    localparam int PROD_W = 14;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [SUM3_W-1:0]  sum3_t;

    function automatic sum3_t add3(input pixel_t a, input pixel_t b, input pixel_t c);
        add3 = sum3_t'(a) + sum3_t'(b) + sum3_t'(c);
    endfunction

    // Magnitude of the difference of two unsigned sums.
    function automatic sum3_t abs_diff(input sum3_t a, input sum3_t b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

[rtl/fded_if.sv]
// Handshake channels of the edge detector: the pixel stream in and the result
// stream out, each with valid, ready and its payload. Depends on fded_pkg.
interface fded_pixel_if
    import fded_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface fded_result_if
    import fded_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              edge_res;
    logic [CROW_W-1:0] center_row;
    logic [CCOL_W-1:0] center_col;
    logic              frame_end;

    modport source (output valid, output edge_res, output center_row, output center_col,
                    output frame_end, input ready);
    modport sink   (input valid, input edge_res, input center_row, input center_col,
                    input frame_end, output ready);
endinterface

[rtl/fded_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the line buffers of the edge detector; no dependencies.
module fded_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/four_direction_edge_detect_core.sv]
// Top level of the four-direction 3x3 edge detector.
// Depends on fded_pkg, the channel interfaces in fded_if.sv and fded_ram.
//
// Usage
// -----
// Grey pixels enter on the "pixels" channel in raster order, one transfer per
// pixel; frame_start set on a transfer restarts the row and column counts at
// that pixel. Every pixel at row r >= 2 and column c >= 2 completes the window
// centred on (r-1, c-1) and yields one transfer on the "results" channel; the
// border pixels yield none. frame_end marks the result of the last interior
// pixel of a frame.
// The block sustains one pixel per clock cycle while the results channel is ready.
// The pixel transfer loads the pixel register and starts the registered line
// buffer read; from these the window is loaded, and from the window the result
// register, which presents the result.
// The user writes the four configuration registers through cfg_wr_en, cfg_index
// and cfg_data only while the stream is idle; the block does not enforce this.
// Reset clears the counters, the window and the handshake state, and loads the
// register defaults; the line buffer RAM is not cleared. When the receiver
// stalls, the result register holds and the stages behind it fill up, so the
// pipeline keeps taking pixels until all three stages are occupied.
module four_direction_edge_detect_core
    import fded_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fded_pixel_if.sink            pixels,
    fded_result_if.source         results
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int LB_W  = 2 * PIXEL_W;

    // Configuration registers.
    logic [IMG_WIDTH_W-1:0]  cfg_width_reg;
    logic [IMG_HEIGHT_W-1:0] cfg_height_reg;
    logic                    cfg_adaptive_reg;
    logic [THRESH_W-1:0]     cfg_thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg    <= IMAGE_WIDTH_RST;
            cfg_height_reg   <= IMAGE_HEIGHT_RST;
            cfg_adaptive_reg <= ADAPTIVE_MODE_RST;
            cfg_thresh_reg   <= EDGE_THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:    cfg_width_reg    <= cfg_data[IMG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:   cfg_height_reg   <= cfg_data[IMG_HEIGHT_W-1:0];
                REG_ADAPTIVE_MODE:  cfg_adaptive_reg <= cfg_data[0];
                REG_EDGE_THRESHOLD: cfg_thresh_reg   <= cfg_data[THRESH_W-1:0];
                default:            cfg_thresh_reg   <= cfg_thresh_reg;
            endcase
        end
    end

    // The frame size is clamped to what the kernel and the line buffers allow.
    logic [31:0] width_clamped;
    logic [31:0] height_clamped;

    always_comb
    begin
        if (32'(cfg_width_reg) < WIN_DIM)
            width_clamped = 32'(WIN_DIM);
        else if (32'(cfg_width_reg) > MAX_WIDTH)
            width_clamped = 32'(MAX_WIDTH);
        else
            width_clamped = 32'(cfg_width_reg);

        if (32'(cfg_height_reg) < WIN_DIM)
            height_clamped = 32'(WIN_DIM);
        else if (32'(cfg_height_reg) > MAX_HEIGHT)
            height_clamped = 32'(MAX_HEIGHT);
        else
            height_clamped = 32'(cfg_height_reg);
    end

    // Pipeline occupancy and flow control. Each stage moves on as soon as the
    // stage ahead of it is empty or emptying, so bubbles close up.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s2_emit_reg;
    logic out_valid_reg;

    logic in_xfer;
    logic out_free;
    logic s2_leave;
    logic s2_free;
    logic s1_leave;

    assign out_free      = !out_valid_reg || results.ready;
    assign s2_leave      = s2_valid_reg && (!s2_emit_reg || out_free);
    assign s2_free       = !s2_valid_reg || s2_leave;
    assign s1_leave      = s1_valid_reg && s2_free;
    assign pixels.ready  = !s1_valid_reg || s1_leave;
    assign in_xfer       = pixels.valid && pixels.ready;

    // Row and column of the incoming pixel.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic [31:0]      col_inc;
    logic [31:0]      row_inc;

    always_comb
    begin
        col_cur = pixels.frame_start ? '0 : col_reg;
        row_cur = pixels.frame_start ? '0 : row_reg;
        col_inc = 32'(col_cur) + 32'd1;
        row_inc = 32'(row_cur) + 32'd1;
        if (col_inc >= width_clamped)
        begin
            col_next = '0;
            row_next = (row_inc >= height_clamped) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: the line buffer entry of the column is read at the transfer.
    // Each entry holds {upper row pixel, middle row pixel}. The entry is
    // rewritten when the pixel leaves stage 1; if the next pixel reads that
    // same column in the same cycle, the new value is forwarded instead.
    logic [PIXEL_W-1:0] s1_px_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_emit_reg;
    logic               s1_fwd_reg;
    logic [LB_W-1:0]    s1_fwd_data_reg;
    logic [LB_W-1:0]    lb_rd_data;
    logic [LB_W-1:0]    lb_entry;
    logic [LB_W-1:0]    lb_wr_data;
    logic [PIXEL_W-1:0] top_px;
    logic [PIXEL_W-1:0] mid_px;

    assign lb_entry   = s1_fwd_reg ? s1_fwd_data_reg : lb_rd_data;
    assign top_px     = lb_entry[LB_W-1:PIXEL_W];
    assign mid_px     = lb_entry[PIXEL_W-1:0];
    assign lb_wr_data = {mid_px, s1_px_reg};

    fded_ram #(
        .DATA_W (LB_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (s1_leave),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr_data),
        .rd_en   (in_xfer),
        .rd_addr (col_cur),
        .rd_data (lb_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_leave)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_px_reg       <= pixels.pixel;
            s1_col_reg      <= col_cur;
            s1_row_reg      <= row_cur;
            s1_emit_reg     <= (32'(row_cur) >= 32'd2) && (32'(col_cur) >= 32'd2);
            s1_fwd_reg      <= s1_valid_reg && (s1_col_reg == col_cur);
            s1_fwd_data_reg <= lb_wr_data;
        end
    end

    // Stage 2: the 3x3 window, row 0 on top and column 2 the newest pixel.
    logic [PIXEL_W-1:0] win_reg [WIN_DIM][WIN_DIM];
    logic [ROW_W-1:0]   s2_row_reg;
    logic [COL_W-1:0]   s2_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int k = 0; k < WIN_DIM; k++)
            begin
                for (int j = 0; j < WIN_DIM; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else if (s1_leave)
        begin
            s2_valid_reg <= 1'b1;
            for (int k = 0; k < WIN_DIM; k++)
            begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= top_px;
            win_reg[1][2] <= mid_px;
            win_reg[2][2] <= s1_px_reg;
        end
        else if (s2_leave)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_leave)
        begin
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_emit_reg <= s1_emit_reg;
        end
    end

    // Gradients with unit weights in the four directions, then the largest
    // magnitude and the decision against the threshold or, in adaptive mode, the window sum.
    sum3_t             g_h;
    sum3_t             g_v;
    sum3_t             g_d1;
    sum3_t             g_d2;
    sum3_t             g_max;
    logic [SUM9_W-1:0] win_sum;
    logic [PROD_W-1:0] max_x12;
    logic              edge_dec;
    logic              last_dec;
    logic [31:0]       crow_full;
    logic [31:0]       ccol_full;

    always_comb
    begin
        g_h  = abs_diff(add3(win_reg[0][2], win_reg[1][2], win_reg[2][2]),
                        add3(win_reg[0][0], win_reg[1][0], win_reg[2][0]));
        g_v  = abs_diff(add3(win_reg[2][0], win_reg[2][1], win_reg[2][2]),
                        add3(win_reg[0][0], win_reg[0][1], win_reg[0][2]));
        g_d1 = abs_diff(add3(win_reg[1][0], win_reg[2][0], win_reg[2][1]),
                        add3(win_reg[0][1], win_reg[0][2], win_reg[1][2]));
        g_d2 = abs_diff(add3(win_reg[1][2], win_reg[2][1], win_reg[2][2]),
                        add3(win_reg[0][0], win_reg[0][1], win_reg[1][0]));

        g_max = g_h;
        if (g_v > g_max)
            g_max = g_v;
        if (g_d1 > g_max)
            g_max = g_d1;
        if (g_d2 > g_max)
            g_max = g_d2;

        win_sum = SUM9_W'(add3(win_reg[0][0], win_reg[0][1], win_reg[0][2]))
                + SUM9_W'(add3(win_reg[1][0], win_reg[1][1], win_reg[1][2]))
                + SUM9_W'(add3(win_reg[2][0], win_reg[2][1], win_reg[2][2]));

        // Twelve times the maximum as eight times plus four times.
        max_x12 = (PROD_W'(g_max) << 3) + (PROD_W'(g_max) << 2);

        if (cfg_adaptive_reg)
            edge_dec = max_x12 > PROD_W'(win_sum);
        else
            edge_dec = g_max > SUM3_W'(cfg_thresh_reg);

        last_dec  = (32'(s2_row_reg) == height_clamped - 32'd1)
                 && (32'(s2_col_reg) == width_clamped - 32'd1);
        crow_full = 32'(s2_row_reg) - 32'd1;
        ccol_full = 32'(s2_col_reg) - 32'd1;
    end

    // Result register.
    logic              out_edge_reg;
    logic [CROW_W-1:0] out_row_reg;
    logic [CCOL_W-1:0] out_col_reg;
    logic              out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_leave && s2_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_leave && s2_emit_reg)
        begin
            out_edge_reg <= edge_dec;
            out_row_reg  <= crow_full[CROW_W-1:0];
            out_col_reg  <= ccol_full[CCOL_W-1:0];
            out_end_reg  <= last_dec;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.edge_res   = out_edge_reg;
    assign results.center_row = out_row_reg;
    assign results.center_col = out_col_reg;
    assign results.frame_end  = out_end_reg;

    // A pixel transfer always lands in stage 1.
    a_xfer_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("pixel transfer did not reach stage 1");

    // Input is refused only when every stage is occupied.
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixels.ready |-> (s1_valid_reg && s2_valid_reg && out_valid_reg))
        else $error("pixel input stalled with a free pipeline stage");

    // A window with a result to give is not dropped while the output stalls.
    a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_emit_reg && !out_free) |=> s2_valid_reg)
        else $error("pending window lost during output stall");

endmodule

[tb/fded_edge_check_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the four-direction edge detector testbench: a bit-exact model
// of the line buffers, window and threshold decision, and the queue of predicted
// result transfers. Depends on fded_pkg.
package fded_edge_check_pkg;
    import fded_pkg::*;

    typedef struct packed {
        logic              edge_res;
        logic [CROW_W-1:0] center_row;
        logic [CCOL_W-1:0] center_col;
        logic              frame_end;
    } edge_mark_t;

    class edge_scoreboard;
        logic [IMG_WIDTH_W-1:0]  image_width;
        logic [IMG_HEIGHT_W-1:0] image_height;
        logic                    adaptive_mode;
        logic [THRESH_W-1:0]     edge_threshold;

        pixel_t      upper_row [MAX_WIDTH_DEF];
        pixel_t      middle_row [MAX_WIDTH_DEF];
        pixel_t      win [WIN_DIM][WIN_DIM];
        int unsigned row_pos;
        int unsigned col_pos;

        edge_mark_t  expected_marks [$];
        int unsigned pixels_seen;
        int unsigned marks_checked;
        int unsigned edges_seen;
        int unsigned frame_ends_seen;
        int unsigned failures;

        function new();
            foreach (upper_row[i])
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[i, j])
            begin
                win[i][j] = '0;
            end
            row_pos         = 0;
            col_pos         = 0;
            image_width     = IMAGE_WIDTH_RST;
            image_height    = IMAGE_HEIGHT_RST;
            adaptive_mode   = ADAPTIVE_MODE_RST;
            edge_threshold  = EDGE_THRESHOLD_RST;
            pixels_seen     = 0;
            marks_checked   = 0;
            edges_seen      = 0;
            frame_ends_seen = 0;
            failures        = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_IMAGE_WIDTH:    image_width    = val[IMG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:   image_height   = val[IMG_HEIGHT_W-1:0];
                REG_ADAPTIVE_MODE:  adaptive_mode  = val[0];
                REG_EDGE_THRESHOLD: edge_threshold = val[THRESH_W-1:0];
                default:            ;
            endcase
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned maxv);
            if (v < WIN_DIM)
            begin
                return WIN_DIM;
            end
            if (v > maxv)
            begin
                return maxv;
            end
            return v;
        endfunction

        function int unsigned eff_width();
            return clamp_size(int'(image_width), MAX_WIDTH_DEF);
        endfunction

        function int unsigned eff_height();
            return clamp_size(int'(image_height), MAX_HEIGHT_DEF);
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function int unsigned pending();
            return expected_marks.size();
        endfunction

        // Advances the window by one accepted pixel and queues the result, if any.
        function void note_pixel(pixel_t px, logic fs);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            pixel_t      top;
            pixel_t      mid;
            int          a [WIN_DIM][WIN_DIM];
            int          g0;
            int          g1;
            int          g2;
            int          g3;
            int          peak;
            int          total;
            edge_mark_t  mark;

            w = eff_width();
            h = eff_height();
            pixels_seen++;
            if (fs)
            begin
                row_pos = 0;
                col_pos = 0;
            end
            r   = row_pos;
            c   = col_pos;
            top = '0;
            mid = '0;
            if (c < MAX_WIDTH_DEF)
            begin
                top           = upper_row[c];
                mid           = middle_row[c];
                upper_row[c]  = mid;
                middle_row[c] = px;
            end
            for (int k = 0; k < WIN_DIM; k++)
            begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = px;

            if (r >= 2 && c >= 2)
            begin
                total = 0;
                foreach (win[i, j])
                begin
                    a[i][j] = int'(win[i][j]);
                    total   = total + a[i][j];
                end
                g0 = (a[0][2] + a[1][2] + a[2][2]) - (a[0][0] + a[1][0] + a[2][0]);
                g1 = (a[2][0] + a[2][1] + a[2][2]) - (a[0][0] + a[0][1] + a[0][2]);
                g2 = (a[1][0] + a[2][0] + a[2][1]) - (a[0][1] + a[0][2] + a[1][2]);
                g3 = (a[1][2] + a[2][1] + a[2][2]) - (a[0][0] + a[0][1] + a[1][0]);
                peak = magnitude(g0);
                if (magnitude(g1) > peak) peak = magnitude(g1);
                if (magnitude(g2) > peak) peak = magnitude(g2);
                if (magnitude(g3) > peak) peak = magnitude(g3);

                if (adaptive_mode)
                begin
                    mark.edge_res = (peak * ADAPT_FACTOR) > total;
                end
                else
                begin
                    mark.edge_res = peak > int'(edge_threshold);
                end
                mark.center_row = CROW_W'(r - 1);
                mark.center_col = CCOL_W'(c - 1);
                mark.frame_end  = (r == h - 1) && (c == w - 1);
                expected_marks.push_back(mark);
            end

            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h)
                begin
                    r = 0;
                end
            end
            row_pos = r;
            col_pos = c;
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got,
                                    edge_mark_t ref_mark);
            if (want != got)
            begin
                failures++;
                $display("%0t ns: window (%0d,%0d) %s expected %0d actual %0d", $time,
                         ref_mark.center_row, ref_mark.center_col, field, want, got);
            end
        endfunction

        function void check_result(edge_mark_t got);
            edge_mark_t want;

            if (expected_marks.size() == 0)
            begin
                failures++;
                $display("%0t ns: result transfer with none expected: row %0d col %0d edge %0b",
                         $time, got.center_row, got.center_col, got.edge_res);
                return;
            end
            want = expected_marks.pop_front();
            marks_checked++;
            if (want.edge_res)  edges_seen++;
            if (want.frame_end) frame_ends_seen++;
            compare_field("edge_res", want.edge_res, got.edge_res, want);
            compare_field("center_row", want.center_row, got.center_row, want);
            compare_field("center_col", want.center_col, got.center_col, want);
            compare_field("frame_end", want.frame_end, got.frame_end, want);
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top-level testbench of the four-direction edge detector: drives pixel frames
// and register settings, and checks every result transfer against the scoreboard.
// Depends on fded_pkg, fded_if.sv, the RTL core and fded_edge_check_pkg.
module tb_top;
    import fded_pkg::*;
    import fded_edge_check_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    // Three pipeline stages plus a margin: long enough for border pixels, which
    // yield no result, to leave the block before a register is rewritten.
    localparam int PIPE_SETTLE   = 8;
    // The limit leaves a wide margin over the slowest correct run for stalls on both sides.
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PIXELS = 120;

    // Distributions of grey levels; the narrow ones make ties between the gradient
    // and the threshold (or twelve times the gradient and the window sum) common.
    typedef enum int {LEVEL_FULL, LEVEL_LOW, LEVEL_RAILS, LEVEL_BAND} level_mode_e;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fded_pixel_if  pix ();
    fded_result_if res ();

    four_direction_edge_detect_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix),
        .results   (res)
    );

    edge_scoreboard sb;
    logic [15:0]    ready_pattern = 16'hFFFF;
    int unsigned    max_gap       = 0;
    level_mode_e    level_mode    = LEVEL_FULL;
    int unsigned    pixels_sent   = 0;
    int unsigned    phases_run    = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // Receiver: ready follows a 16-bit pattern that is chosen afresh for each
    // phase, from always ready to sparse, so stalls fall at every pipeline state.
    initial
    begin : receiver
        logic [3:0] ready_slot;

        ready_slot = '0;
        res.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            res.ready <= ready_pattern[ready_slot];
            ready_slot++;
        end
    end

    // Both channels are sampled at the rising edge, before any of the values
    // driven at that edge take effect, so each transfer is seen exactly as the
    // block sees it.
    always @(posedge clk)
    begin : monitor
        edge_mark_t got;

        if (rst_n)
        begin
            if (pix.valid && pix.ready)
            begin
                sb.note_pixel(pix.pixel, pix.frame_start);
            end
            if (res.valid && res.ready)
            begin
                got.edge_res   = res.edge_res;
                got.center_row = res.center_row;
                got.center_col = res.center_col;
                got.frame_end  = res.frame_end;
                sb.check_result(got);
            end
        end
    end

    // Watchdog: a run that has not finished by now has hung somewhere.
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Run did not complete within %0d cycles.", CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One register write; cfg_wr_en stays high so that writes can follow back to
    // back, and the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        sb.set_register(idx, CFG_DATA_W'(val));
        @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has arrived, then give
    // any border pixels still in flight time to leave the pipeline.
    task automatic settle();
        pix.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // Presents one pixel and returns at the edge where the transfer happens.
    // Valid is left high so that the next pixel can follow without a bubble.
    task automatic send_pixel(input pixel_t px, input logic fs);
        pix.valid       <= 1'b1;
        pix.pixel       <= px;
        pix.frame_start <= fs;
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        pixels_sent++;
    endtask

    function automatic pixel_t next_level();
        case (level_mode)
            LEVEL_LOW:   return pixel_t'($urandom_range(0, 3));
            LEVEL_RAILS: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            LEVEL_BAND:  return pixel_t'(120 + $urandom_range(0, 15));
            default:     return pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int unsigned pick_threshold();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 8);
            1:       return ($urandom_range(0, 1) != 0) ? 255 : 0;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // The sender works in bursts of random length separated by random gaps; a
    // maximum gap of zero gives an unbroken stream. Mid-frame restarts are mixed
    // in now and then to break the frame structure.
    task automatic stream_pixels(input int unsigned count, input logic first_fs);
        int unsigned burst_left;
        int unsigned gap;
        logic        fs;

        burst_left = $urandom_range(1, 24);
        for (int unsigned k = 0; k < count; k++)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, max_gap);
                repeat (gap)
                begin
                    pix.valid <= 1'b0;
                    @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            if (k == 0)
            begin
                fs = first_fs;
            end
            else
            begin
                fs = ($urandom_range(0, 99) < 2);
            end
            send_pixel(next_level(), fs);
            burst_left--;
        end
    endtask

    // One configuration phase: drain, rewrite the sizes (and mostly the mode and
    // threshold), choose the traffic shape, then stream whole frames plus a
    // partial one. When the width grows the new frame must begin with a restart,
    // otherwise the line buffers would be read at columns never written; when it
    // shrinks or stays, the frame in progress may simply carry on, which also
    // covers a pixel landing at a column beyond the new width.
    task automatic run_phase(input int unsigned w_val, input int unsigned h_val,
                             input int unsigned frames, input int unsigned extra_max);
        int unsigned old_w;
        int unsigned new_w;
        int unsigned extra;
        logic        first_fs;

        settle();
        old_w = sb.eff_width();
        write_reg(REG_IMAGE_WIDTH, w_val);
        write_reg(REG_IMAGE_HEIGHT, h_val);
        if ($urandom_range(0, 4) != 0) write_reg(REG_ADAPTIVE_MODE, $urandom_range(0, 1));
        if ($urandom_range(0, 4) != 0) write_reg(REG_EDGE_THRESHOLD, pick_threshold());
        cfg_wr_en <= 1'b0;

        case ($urandom_range(0, 3))
            0:       ready_pattern = 16'hFFFF;
            1:       ready_pattern = 16'($urandom);
            2:       ready_pattern = 16'($urandom & $urandom);
            default: ready_pattern = 16'($urandom | $urandom);
        endcase
        if (ready_pattern == 16'h0000) ready_pattern = 16'h0001;
        max_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        case ($urandom_range(0, 5))
            0:       level_mode = LEVEL_LOW;
            1:       level_mode = LEVEL_RAILS;
            2:       level_mode = LEVEL_BAND;
            default: level_mode = LEVEL_FULL;
        endcase

        new_w    = sb.eff_width();
        first_fs = (new_w > old_w) ? 1'b1 : logic'($urandom_range(0, 1));
        extra    = $urandom_range(0, extra_max);
        if (frames == 0 && extra == 0) extra = 1;
        stream_pixels(frames * new_w * sb.eff_height() + extra, first_fs);
        phases_run++;
    endtask

    initial
    begin : stimulus
        int unsigned random_start;

        sb              = new();
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_IMAGE_WIDTH;
        cfg_data        = '0;
        pix.valid       = 1'b0;
        pix.pixel       = '0;
        pix.frame_start = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a 3x3 frame under the reset mode and threshold, with a hard
        // vertical step from black to white that must be marked.
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 3);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                send_pixel((c == 2) ? 8'hFF : 8'h00, 1'b0);
            end
        end

        // Directed: adaptive mode, full threshold, a wider frame that starts with
        // a restart and carries a white diagonal on black.
        settle();
        write_reg(REG_ADAPTIVE_MODE, 1);
        write_reg(REG_EDGE_THRESHOLD, 255);
        write_reg(REG_IMAGE_WIDTH, 4);
        cfg_wr_en <= 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                send_pixel((r == c) ? 8'hFF : 8'h00, (r == 0 && c == 0));
            end
        end
        phases_run = 2;

        // Random phases, mostly small frames, with sizes below the kernel and
        // above the usual range now and then to exercise the clamping.
        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS)
        begin
            int unsigned w_val;
            int unsigned h_val;

            case ($urandom_range(0, 9))
                0:       w_val = $urandom_range(0, 2);
                1:       w_val = $urandom_range(13, 40);
                default: w_val = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       h_val = $urandom_range(0, 2);
                1:       h_val = $urandom_range(7, 12);
                default: h_val = $urandom_range(3, 6);
            endcase
            run_phase(w_val, h_val, $urandom_range(0, 2), 2 * w_val + 2);
        end

        // The size extremes: one whole frame with the width clamped from above
        // to the full line buffer and the height clamped up to the window, then
        // a few pixels with the height clamped from above.
        run_phase(511, 0, 1, 8);
        run_phase(2, 2047, 0, 40);

        settle();
        $display("Covered %0d pixel transfers over %0d register settings, widths 3 to 256.",
                 sb.pixels_seen, phases_run);
        $display("Checked %0d result transfers: %0d edges, %0d frame ends, %0d failures.",
                 sb.marks_checked, sb.edges_seen, sb.frame_ends_seen, sb.failures);
        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/fded_pkg.sv
rtl/fded_if.sv
rtl/fded_ram.sv
rtl/four_direction_edge_detect_core.sv
tb/fded_edge_check_pkg.sv
tb/tb_top.sv
